// File: rtl/ogu_pkg.sv
// Shared types and constants of the occupancy grid update block.
// Depends on nothing; all files but ogu_ram use it by scoped names.
`default_nettype none

package ogu_pkg;

   // grid geometry
   localparam int GRID_ROWS  = 64;
   localparam int GRID_COLS  = 128;
   localparam int CELL_COUNT = GRID_ROWS * GRID_COLS;
   localparam int ADDR_W     = $clog2(CELL_COUNT);
   localparam int ROW_W      = $clog2(GRID_ROWS);
   localparam int COL_W      = $clog2(GRID_COLS);

   // field widths
   localparam int POS_W     = 12;
   localparam int OFFSET_W  = 12;
   localparam int OCC_W     = 8;
   localparam int CMD_W     = 2;
   localparam int COORD_W   = POS_W + 2;

   // command codes on the input word
   localparam logic [CMD_W-1:0] CMD_SONAR = 2'd0;
   localparam logic [CMD_W-1:0] CMD_OTHER = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

   // configuration register map (word index) and reset values
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam logic [2:0] REG_COLUMN_OFFSET = 3'd0;
   localparam logic [2:0] REG_ROW_OFFSET    = 3'd1;
   localparam logic [2:0] REG_STEP          = 3'd2;
   localparam logic [2:0] REG_CEILING       = 3'd3;
   localparam logic [2:0] REG_THRESHOLD     = 3'd4;

   localparam logic [OFFSET_W-1:0] RST_COLUMN_OFFSET = 12'd64;
   localparam logic [OFFSET_W-1:0] RST_ROW_OFFSET    = 12'd32;
   localparam logic [OCC_W-1:0]    RST_STEP          = 8'd5;
   localparam logic [OCC_W-1:0]    RST_CEILING       = 8'd250;
   localparam logic [OCC_W-1:0]    RST_THRESHOLD     = 8'd16;

   // queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic             object;
      logic             other;
      logic             sonar;
      logic [OCC_W-1:0] occ;
   } cell_type;

   localparam int CELL_W = $bits(cell_type);

   typedef enum logic [1:0] {
      KIND_READ,
      KIND_SONAR,
      KIND_OTHER
   } kind_type;

   typedef struct packed {
      kind_type          kind;
      logic              on_grid;
      logic [ADDR_W-1:0] addr;
      logic              last;
   } work_type;

   typedef struct packed {
      logic     valid;
      work_type work;
   } queue_head_type;

   typedef struct packed {
      logic [OCC_W-1:0] step;
      logic [OCC_W-1:0] ceiling;
      logic [OCC_W-1:0] threshold;
   } update_cfg_type;

   typedef struct packed {
      logic clearing;
   } back_status_type;

endpackage

`default_nettype wire

// File: rtl/ogu_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
`default_nettype none

module ogu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/ogu_front.sv
// Front end: accepts input words, offsets the point into the grid and
// classifies it into a work entry for the queue. Uses ogu_pkg.
`default_nettype none

module ogu_front (
   input  wire logic                           start,
   input  wire logic [ogu_pkg::CMD_W-1:0]      req_cmd,
   input  wire logic signed [ogu_pkg::POS_W-1:0] req_pos_x,
   input  wire logic signed [ogu_pkg::POS_W-1:0] req_pos_y,
   input  wire logic                           req_cluster_active,
   input  wire logic                           req_last_in_frame,
   input  wire logic [ogu_pkg::OFFSET_W-1:0]   column_offset,
   input  wire logic [ogu_pkg::OFFSET_W-1:0]   row_offset,
   input  wire logic                           queue_full,
   input  wire ogu_pkg::back_status_type       back_status,
   output logic                                busy,
   output logic                                push,
   output ogu_pkg::work_type                   work
);

   logic signed [ogu_pkg::COORD_W-1:0] col;
   logic signed [ogu_pkg::COORD_W-1:0] row;
   logic                               col_ok;
   logic                               row_ok;
   logic                               on_grid;
   logic [ogu_pkg::COL_W-1:0]          col_idx;
   logic [ogu_pkg::ROW_W-1:0]          row_idx;
   logic                               hit;

   always_comb begin
      col = ogu_pkg::COORD_W'(req_pos_x) +
            $signed({2'b00, column_offset});
      row = ogu_pkg::COORD_W'(req_pos_y) +
            $signed({2'b00, row_offset});
      col_ok = !col[ogu_pkg::COORD_W-1] &&
               (ogu_pkg::COORD_W'(col) < ogu_pkg::COORD_W'(ogu_pkg::GRID_COLS));
      row_ok = !row[ogu_pkg::COORD_W-1] &&
               (ogu_pkg::COORD_W'(row) < ogu_pkg::COORD_W'(ogu_pkg::GRID_ROWS));
      on_grid = col_ok && row_ok;
      col_idx = col[ogu_pkg::COL_W-1:0];
      row_idx = row[ogu_pkg::ROW_W-1:0];
      hit     = on_grid && req_cluster_active &&
                ((req_cmd == ogu_pkg::CMD_SONAR) || (req_cmd == ogu_pkg::CMD_OTHER));

      work.on_grid = on_grid;
      work.last    = req_last_in_frame;
      work.addr    = ogu_pkg::ADDR_W'(ogu_pkg::ADDR_W'(row_idx) *
                                      ogu_pkg::ADDR_W'(ogu_pkg::GRID_COLS)) +
                     ogu_pkg::ADDR_W'(col_idx);
      if (!hit) begin
         work.kind = ogu_pkg::KIND_READ;
      end else if (req_cmd == ogu_pkg::CMD_SONAR) begin
         work.kind = ogu_pkg::KIND_SONAR;
      end else begin
         work.kind = ogu_pkg::KIND_OTHER;
      end

      busy = back_status.clearing || queue_full;
      push = start && !busy;
   end

endmodule

`default_nettype wire

// File: rtl/ogu_queue.sv
// Short work queue between front and back end.
// Uses ogu_pkg for the entry type and depth.
`default_nettype none

module ogu_queue (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire ogu_pkg::work_type      work_in,
   input  wire logic                   pop,
   output ogu_pkg::queue_head_type     head,
   output logic                        full
);

   ogu_pkg::work_type                 slot_ff [ogu_pkg::QUEUE_DEPTH];
   logic [ogu_pkg::QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [ogu_pkg::QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [ogu_pkg::QUEUE_CNT_W-1:0]   count_ff, count_in;
   logic                              do_pop;

   always_comb begin
      do_pop    = pop && (count_ff != '0);
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == ogu_pkg::QUEUE_PTR_W'(ogu_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == ogu_pkg::QUEUE_PTR_W'(ogu_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= work_in;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.work  = slot_ff[rd_ptr_ff];
   assign full       = (count_ff == ogu_pkg::QUEUE_CNT_W'(ogu_pkg::QUEUE_DEPTH));

endmodule

`default_nettype wire

// File: rtl/ogu_back.sv
// Back end: clears the grid after reset, then reads the grid memory per queued
// word, writes hits back updated and registers the result. Uses ogu_pkg, ogu_ram.
`default_nettype none

module ogu_back (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire ogu_pkg::queue_head_type  head,
   input  wire ogu_pkg::update_cfg_type  cfg,
   output logic                          pop,
   output ogu_pkg::back_status_type      status,
   output logic                          rsp_strobe,
   output logic                          rsp_in_range,
   output logic [ogu_pkg::OCC_W-1:0]     rsp_occupancy,
   output logic                          rsp_sonar_seen,
   output logic                          rsp_other_seen,
   output logic                          rsp_object_set,
   output logic                          rsp_frame_done
);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ
   } state_type;

   state_type                     state_ff, state_in;
   logic [ogu_pkg::ADDR_W-1:0]    clr_cnt_ff, clr_cnt_in;
   ogu_pkg::work_type             cur_ff, cur_in;
   logic                          strobe_ff, strobe_in;
   logic                          in_range_ff, in_range_in;
   logic                          last_ff, last_in;
   ogu_pkg::cell_type             cell_out_ff, cell_out_in;

   logic                          wr_en;
   logic [ogu_pkg::ADDR_W-1:0]    wr_addr;
   ogu_pkg::cell_type             wr_cell;
   ogu_pkg::cell_type             rd_cell;
   logic [ogu_pkg::CELL_W-1:0]    rd_bits;
   ogu_pkg::cell_type             upd_cell;
   logic [ogu_pkg::OCC_W:0]       occ_sum;
   logic [ogu_pkg::OCC_W-1:0]     occ_new;

   ogu_ram #(
      .WIDTH (ogu_pkg::CELL_W),
      .DEPTH (ogu_pkg::CELL_COUNT)
   ) u_grid (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_cell),
      .rd_addr (head.work.addr),
      .rd_data (rd_bits)
   );

   assign rd_cell = ogu_pkg::cell_type'(rd_bits);

   // saturating count update and flag merge
   always_comb begin
      occ_sum = {1'b0, rd_cell.occ} + {1'b0, cfg.step};
      occ_new = (occ_sum > {1'b0, cfg.ceiling}) ? cfg.ceiling : occ_sum[ogu_pkg::OCC_W-1:0];
      upd_cell        = rd_cell;
      upd_cell.occ    = occ_new;
      upd_cell.sonar  = rd_cell.sonar || (cur_ff.kind == ogu_pkg::KIND_SONAR);
      upd_cell.other  = rd_cell.other || (cur_ff.kind == ogu_pkg::KIND_OTHER);
      upd_cell.object = rd_cell.object || (occ_new >= cfg.threshold);
   end

   always_comb begin
      state_in    = state_ff;
      clr_cnt_in  = clr_cnt_ff;
      cur_in      = cur_ff;
      strobe_in   = 1'b0;
      in_range_in = in_range_ff;
      last_in     = last_ff;
      cell_out_in = cell_out_ff;
      pop         = 1'b0;
      wr_en       = 1'b0;
      wr_addr     = cur_ff.addr;
      wr_cell     = upd_cell;

      case (state_ff)
         ST_CLEAR: begin
            wr_en      = 1'b1;
            wr_addr    = clr_cnt_ff;
            wr_cell    = '0;
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == ogu_pkg::ADDR_W'(ogu_pkg::CELL_COUNT - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (head.valid) begin
               pop      = 1'b1;
               cur_in   = head.work;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            wr_en       = (cur_ff.kind != ogu_pkg::KIND_READ);
            strobe_in   = 1'b1;
            in_range_in = cur_ff.on_grid;
            last_in     = cur_ff.last;
            if (!cur_ff.on_grid) begin
               cell_out_in = '0;
            end else if (cur_ff.kind != ogu_pkg::KIND_READ) begin
               cell_out_in = upd_cell;
            end else begin
               cell_out_in = rd_cell;
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_cnt_ff <= '0;
         strobe_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         clr_cnt_ff <= clr_cnt_in;
         strobe_ff  <= strobe_in;
      end
      cur_ff      <= cur_in;
      in_range_ff <= in_range_in;
      last_ff     <= last_in;
      cell_out_ff <= cell_out_in;
   end

   assign status.clearing = (state_ff == ST_CLEAR);
   assign rsp_strobe      = strobe_ff;
   assign rsp_in_range    = in_range_ff;
   assign rsp_occupancy   = cell_out_ff.occ;
   assign rsp_sonar_seen  = cell_out_ff.sonar;
   assign rsp_other_seen  = cell_out_ff.other;
   assign rsp_object_set  = cell_out_ff.object;
   assign rsp_frame_done  = last_ff;

endmodule

`default_nettype wire

// File: rtl/occupancy_grid_update.sv
// Occupancy grid update, top level: register port, front end, queue, back end.
// Uses ogu_pkg, ogu_front, ogu_queue, ogu_back.
//
// Usage:
//  - Input channel: drive req_* and raise start; the word is taken at a rising
//    edge where start is high and busy is low. Each word is a sonar hit, a
//    second-sensor hit or a plain cell read at point (pos_x, pos_y).
//  - Result channel: every word gives exactly one result word, shown on rsp_*
//    for one cycle while rsp_strobe is high. The receiver cannot stall; take
//    the word in that cycle or lose it.
//  - Path: a word taken into an empty block goes through the queue, the grid
//    memory read and the update before its result shows.
//  - Pacing: the back end finishes the grid memory read-modify-write of one
//    word (read, then write for a hit and result) before it takes the next. The
//    front end takes words into a 2-entry queue and raises busy when it fills.
//  - Reset: the register file returns to its reset values and the back end
//    sweeps the whole grid to zero, one cell a cycle, GRID_ROWS*GRID_COLS cells
//    (8192 at the default size). busy stays high for the sweep.
//  - Registers (APB, word index = paddr[4:2]): column offset, row offset,
//    occupancy step, occupancy ceiling, object threshold. Write them only
//    while no word is in flight.
`default_nettype none

module occupancy_grid_update (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // input channel
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic [ogu_pkg::CMD_W-1:0]         req_cmd,
   input  wire logic signed [ogu_pkg::POS_W-1:0]  req_pos_x,
   input  wire logic signed [ogu_pkg::POS_W-1:0]  req_pos_y,
   input  wire logic                              req_cluster_active,
   input  wire logic                              req_last_in_frame,
   // result channel
   output logic                                   rsp_strobe,
   output logic                                   rsp_in_range,
   output logic [ogu_pkg::OCC_W-1:0]              rsp_occupancy,
   output logic                                   rsp_sonar_seen,
   output logic                                   rsp_other_seen,
   output logic                                   rsp_object_set,
   output logic                                   rsp_frame_done,
   // register port
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [ogu_pkg::CSR_ADDR_W-1:0]    paddr,
   input  wire logic [ogu_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [ogu_pkg::CSR_DATA_W-1:0]         prdata,
   output logic                                   pready
);

   // configuration registers
   logic [ogu_pkg::OFFSET_W-1:0] col_off_ff, col_off_in;
   logic [ogu_pkg::OFFSET_W-1:0] row_off_ff, row_off_in;
   logic [ogu_pkg::OCC_W-1:0]    step_ff, step_in;
   logic [ogu_pkg::OCC_W-1:0]    ceiling_ff, ceiling_in;
   logic [ogu_pkg::OCC_W-1:0]    thresh_ff, thresh_in;

   logic                         csr_write;
   logic [2:0]                   csr_index;

   ogu_pkg::work_type            front_work;
   logic                         push;
   logic                         pop;
   logic                         queue_full;
   ogu_pkg::queue_head_type      queue_head;
   ogu_pkg::back_status_type     back_status;
   ogu_pkg::update_cfg_type      update_cfg;

   assign pready    = 1'b1;
   assign csr_index = paddr[4:2];
   assign csr_write = psel && penable && pwrite;

   // decode the write; an index past the list is dropped
   always_comb begin
      col_off_in = col_off_ff;
      row_off_in = row_off_ff;
      step_in    = step_ff;
      ceiling_in = ceiling_ff;
      thresh_in  = thresh_ff;
      if (csr_write) begin
         case (csr_index)
            ogu_pkg::REG_COLUMN_OFFSET: col_off_in = pwdata[ogu_pkg::OFFSET_W-1:0];
            ogu_pkg::REG_ROW_OFFSET:    row_off_in = pwdata[ogu_pkg::OFFSET_W-1:0];
            ogu_pkg::REG_STEP:          step_in    = pwdata[ogu_pkg::OCC_W-1:0];
            ogu_pkg::REG_CEILING:       ceiling_in = pwdata[ogu_pkg::OCC_W-1:0];
            ogu_pkg::REG_THRESHOLD:     thresh_in  = pwdata[ogu_pkg::OCC_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_off_ff <= ogu_pkg::RST_COLUMN_OFFSET;
         row_off_ff <= ogu_pkg::RST_ROW_OFFSET;
         step_ff    <= ogu_pkg::RST_STEP;
         ceiling_ff <= ogu_pkg::RST_CEILING;
         thresh_ff  <= ogu_pkg::RST_THRESHOLD;
      end else begin
         col_off_ff <= col_off_in;
         row_off_ff <= row_off_in;
         step_ff    <= step_in;
         ceiling_ff <= ceiling_in;
         thresh_ff  <= thresh_in;
      end
   end

   // read back, zero-extended
   always_comb begin
      case (csr_index)
         ogu_pkg::REG_COLUMN_OFFSET: prdata = ogu_pkg::CSR_DATA_W'(col_off_ff);
         ogu_pkg::REG_ROW_OFFSET:    prdata = ogu_pkg::CSR_DATA_W'(row_off_ff);
         ogu_pkg::REG_STEP:          prdata = ogu_pkg::CSR_DATA_W'(step_ff);
         ogu_pkg::REG_CEILING:       prdata = ogu_pkg::CSR_DATA_W'(ceiling_ff);
         ogu_pkg::REG_THRESHOLD:     prdata = ogu_pkg::CSR_DATA_W'(thresh_ff);
         default:                    prdata = '0;
      endcase
   end

   assign update_cfg.step      = step_ff;
   assign update_cfg.ceiling   = ceiling_ff;
   assign update_cfg.threshold = thresh_ff;

   // accept and classify
   ogu_front u_front (
      .start              (start),
      .req_cmd            (req_cmd),
      .req_pos_x          (req_pos_x),
      .req_pos_y          (req_pos_y),
      .req_cluster_active (req_cluster_active),
      .req_last_in_frame  (req_last_in_frame),
      .column_offset      (col_off_ff),
      .row_offset         (row_off_ff),
      .queue_full         (queue_full),
      .back_status        (back_status),
      .busy               (busy),
      .push               (push),
      .work               (front_work)
   );

   // hold classified words until the back end is free
   ogu_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .work_in (front_work),
      .pop     (pop),
      .head    (queue_head),
      .full    (queue_full)
   );

   // clear sweep, read-modify-write, result register
   ogu_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (queue_head),
      .cfg            (update_cfg),
      .pop            (pop),
      .status         (back_status),
      .rsp_strobe     (rsp_strobe),
      .rsp_in_range   (rsp_in_range),
      .rsp_occupancy  (rsp_occupancy),
      .rsp_sonar_seen (rsp_sonar_seen),
      .rsp_other_seen (rsp_other_seen),
      .rsp_object_set (rsp_object_set),
      .rsp_frame_done (rsp_frame_done)
   );

endmodule

`default_nettype wire

// File: rtl/ogu_checker.sv
// Port-level checks for occupancy_grid_update, bound to the top level.
// Uses ogu_pkg for widths.
`default_nettype none

module ogu_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              busy,
   input wire logic                              rsp_strobe,
   input wire logic                              rsp_in_range,
   input wire logic [ogu_pkg::OCC_W-1:0]         rsp_occupancy,
   input wire logic                              rsp_sonar_seen,
   input wire logic                              rsp_other_seen,
   input wire logic                              rsp_object_set,
   input wire logic                              psel,
   input wire logic                              penable,
   input wire logic                              pwrite,
   input wire logic [ogu_pkg::CSR_ADDR_W-1:0]    paddr,
   input wire logic [ogu_pkg::CSR_DATA_W-1:0]    pwdata,
   input wire logic [ogu_pkg::CSR_DATA_W-1:0]    prdata
);

   // the grid sweep starts right out of reset, so the block is busy
   a_busy_after_reset: assert property (@(posedge clock)
      reset |=> busy)
      else $error("busy low right after reset");

   // each word needs a read and a result step: no two results back to back
   a_strobe_spacing: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("results on consecutive cycles");

   // a point outside the grid reports an empty cell
   a_outside_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_in_range) |->
         (rsp_occupancy == '0) && !rsp_sonar_seen && !rsp_other_seen && !rsp_object_set)
      else $error("outside point reports cell contents");

   // a column offset write reads back on the next cycle
   a_csr_readback: assert property (@(posedge clock) disable iff (reset)
      (psel && penable && pwrite && (paddr[4:2] == ogu_pkg::REG_COLUMN_OFFSET))
         ##1 (paddr[4:2] == ogu_pkg::REG_COLUMN_OFFSET)
         |-> (prdata[ogu_pkg::OFFSET_W-1:0] == $past(pwdata[ogu_pkg::OFFSET_W-1:0])))
      else $error("column offset readback mismatch");

endmodule

bind occupancy_grid_update ogu_checker u_ogu_checker (.*);

`default_nettype wire

// File: dv/tb_occupancy_grid_update.sv
// Self-checking bench for occupancy_grid_update: directed points, then random bursts
// of points, checked against a grid mirror. Uses ogu_pkg and the RTL top level.
`timescale 1ns / 1ps

module tb_occupancy_grid_update;

   // cmd 3 is not decoded by the block; it must behave as a plain read
   localparam logic [ogu_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int HOT_CELLS = 6;
   localparam int PHASES = 10;
   localparam int FIXED_PHASES = 7;
   // idle wait once every result is in, as slack before the next step
   localparam int SETTLE_CYCLES = 8;

   typedef struct packed {
      logic [ogu_pkg::CMD_W-1:0] cmd;
      logic [ogu_pkg::POS_W-1:0] pos_x;
      logic [ogu_pkg::POS_W-1:0] pos_y;
      logic                      active;
      logic                      last;
   } point_word_type;

   typedef struct packed {
      logic                      in_range;
      logic [ogu_pkg::OCC_W-1:0] occ;
      logic                      sonar;
      logic                      other;
      logic                      object;
      logic                      frame;
   } cell_report_type;

   // one row of the directed stimulus; the typed fields are only used when typed is set
   typedef struct {
      int cmd;
      int x;
      int y;
      bit active;
      bit last;
      bit typed;
      bit in_range;
      int occ;
      bit sonar;
      bit other;
      bit object;
   } point_row_type;

   typedef struct {
      int col_off;
      int row_off;
      int step;
      int ceil;
      int thr;
   } grid_setting_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic [ogu_pkg::CMD_W-1:0]        req_cmd = '0;
   logic signed [ogu_pkg::POS_W-1:0] req_pos_x = '0;
   logic signed [ogu_pkg::POS_W-1:0] req_pos_y = '0;
   logic                 req_cluster_active = 1'b0;
   logic                 req_last_in_frame = 1'b0;
   logic                 rsp_strobe;
   logic                 rsp_in_range;
   logic [ogu_pkg::OCC_W-1:0] rsp_occupancy;
   logic                 rsp_sonar_seen;
   logic                 rsp_other_seen;
   logic                 rsp_object_set;
   logic                 rsp_frame_done;
   logic                 psel = 1'b0;
   logic                 penable = 1'b0;
   logic                 pwrite = 1'b0;
   logic [ogu_pkg::CSR_ADDR_W-1:0] paddr = '0;
   logic [ogu_pkg::CSR_DATA_W-1:0] pwdata = '0;
   logic [ogu_pkg::CSR_DATA_W-1:0] prdata;
   logic                 pready;

   occupancy_grid_update dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_cmd            (req_cmd),
      .req_pos_x          (req_pos_x),
      .req_pos_y          (req_pos_y),
      .req_cluster_active (req_cluster_active),
      .req_last_in_frame  (req_last_in_frame),
      .rsp_strobe         (rsp_strobe),
      .rsp_in_range       (rsp_in_range),
      .rsp_occupancy      (rsp_occupancy),
      .rsp_sonar_seen     (rsp_sonar_seen),
      .rsp_other_seen     (rsp_other_seen),
      .rsp_object_set     (rsp_object_set),
      .rsp_frame_done     (rsp_frame_done),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   always #5 clock = ~clock;

   // mirror of the grid and of the register file, kept in step with accepted words
   ogu_pkg::cell_type   grid_mirror [ogu_pkg::CELL_COUNT];
   logic [ogu_pkg::OFFSET_W-1:0] grid_col_offset = ogu_pkg::RST_COLUMN_OFFSET;
   logic [ogu_pkg::OFFSET_W-1:0] grid_row_offset = ogu_pkg::RST_ROW_OFFSET;
   logic [ogu_pkg::OCC_W-1:0]    hit_step        = ogu_pkg::RST_STEP;
   logic [ogu_pkg::OCC_W-1:0]    count_ceiling   = ogu_pkg::RST_CEILING;
   logic [ogu_pkg::OCC_W-1:0]    object_level    = ogu_pkg::RST_THRESHOLD;

   cell_report_type pending_reports [$];
   int              failures = 0;
   int              burst_left = 0;

   // Directed points at reset settings (column offset 64, row offset 32): grid origin
   // sits at sensor (-64,-32), so (0,0) is cell column 64 row 32.
   point_row_type directed_points [24] = '{
      // fresh cell after the clearing sweep reads back as all zero
      '{ogu_pkg::CMD_READ,     0,     0, 1, 0, 1, 1, 0, 0, 0, 0},
      // first sonar hit adds one step
      '{ogu_pkg::CMD_SONAR,    0,     0, 1, 0, 1, 1, 5, 1, 0, 0},
      '{ogu_pkg::CMD_OTHER,    0,     0, 1, 0, 0, 0, 0, 0, 0, 0},
      '{ogu_pkg::CMD_SONAR,    0,     0, 1, 1, 0, 0, 0, 0, 0, 0},
      // count reaches the threshold here
      '{ogu_pkg::CMD_OTHER,    0,     0, 1, 0, 0, 0, 0, 0, 0, 0},
      // inactive cluster leaves the cell alone
      '{ogu_pkg::CMD_SONAR,    0,     0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ogu_pkg::CMD_OTHER,    5,     5, 0, 1, 0, 0, 0, 0, 0, 0},
      // unused command acts as a read
      '{CMD_UNUSED,            0,     0, 1, 0, 0, 0, 0, 0, 0, 0},
      '{ogu_pkg::CMD_READ,     0,     0, 0, 1, 0, 0, 0, 0, 0, 0},
      // the four grid corners
      '{ogu_pkg::CMD_SONAR,  -64,   -32, 1, 0, 0, 0, 0, 0, 0, 0},
      '{ogu_pkg::CMD_OTHER,   63,    31, 1, 0, 0, 0, 0, 0, 0, 0},
      '{ogu_pkg::CMD_SONAR,   63,   -32, 1, 1, 0, 0, 0, 0, 0, 0},
      '{ogu_pkg::CMD_OTHER,  -64,    31, 1, 0, 0, 0, 0, 0, 0, 0},
      // one step past each edge: nothing written, only the frame flag echoes
      '{ogu_pkg::CMD_SONAR,   64,     0, 1, 1, 1, 0, 0, 0, 0, 0},
      '{ogu_pkg::CMD_OTHER,  -65,     0, 1, 0, 1, 0, 0, 0, 0, 0},
      '{ogu_pkg::CMD_SONAR,    0,    32, 1, 0, 1, 0, 0, 0, 0, 0},
      '{ogu_pkg::CMD_SONAR,    0,   -33, 1, 1, 1, 0, 0, 0, 0, 0},
      // coordinate extremes, all far outside the grid
      '{ogu_pkg::CMD_OTHER, -2048, -2048, 1, 0, 1, 0, 0, 0, 0, 0},
      '{ogu_pkg::CMD_SONAR,  2047,  2047, 1, 1, 1, 0, 0, 0, 0, 0},
      '{ogu_pkg::CMD_READ,   2047, -2048, 1, 0, 1, 0, 0, 0, 0, 0},
      '{CMD_UNUSED,         -2048,  2047, 0, 1, 1, 0, 0, 0, 0, 0},
      // back-to-back hits on one cell exercise the read-modify-write
      '{ogu_pkg::CMD_SONAR,    0,     0, 1, 0, 0, 0, 0, 0, 0, 0},
      '{ogu_pkg::CMD_SONAR,    0,     0, 1, 0, 0, 0, 0, 0, 0, 0},
      '{ogu_pkg::CMD_READ,   -64,   -32, 1, 0, 0, 0, 0, 0, 0, 0}
   };

   // phase 0 runs on reset values; the others are written before their phase starts
   grid_setting_type fixed_settings [FIXED_PHASES] = '{
      '{64,   32,   5,   250, 16},
      '{64,   32,   255, 255, 255},   // one hit saturates at full scale
      '{64,   32,   1,   255, 0},     // threshold zero: every hit marks an object
      '{64,   32,   7,   0,   16},    // ceiling below existing counts pulls them down
      '{0,    0,    0,   100, 0},     // zero step, grid starts at sensor origin
      '{4095, 4095, 3,   250, 16},    // largest offsets: every point misses the grid
      '{2100, 2050, 9,   200, 40}     // grid near the negative coordinate limit
   };
   int phase_points [PHASES] = '{90, 70, 70, 60, 60, 30, 70, 70, 70, 70};

   // Work out the cell after one word and update the mirror the same way the block must.
   function automatic cell_report_type predict_cell_update(input point_word_type w);
      int                col;
      int                row;
      int                addr;
      int unsigned       sum;
      ogu_pkg::cell_type entry;
      cell_report_type   r;
      col = int'($signed(w.pos_x)) + int'(grid_col_offset);
      row = int'($signed(w.pos_y)) + int'(grid_row_offset);
      r = '0;
      r.frame = w.last;
      if (col >= 0 && col < ogu_pkg::GRID_COLS && row >= 0 && row < ogu_pkg::GRID_ROWS) begin
         addr = row * ogu_pkg::GRID_COLS + col;
         entry = grid_mirror[addr];
         if ((w.cmd == ogu_pkg::CMD_SONAR || w.cmd == ogu_pkg::CMD_OTHER) && w.active) begin
            sum = int'(entry.occ) + int'(hit_step);
            // clamp, which also pulls a count above a lowered ceiling down to it
            if (sum > count_ceiling)
               sum = count_ceiling;
            entry.occ = sum[ogu_pkg::OCC_W-1:0];
            if (w.cmd == ogu_pkg::CMD_SONAR)
               entry.sonar = 1'b1;
            else
               entry.other = 1'b1;
            if (sum >= object_level)
               entry.object = 1'b1;
            grid_mirror[addr] = entry;
         end
         r.in_range = 1'b1;
         r.occ      = entry.occ;
         r.sonar    = entry.sonar;
         r.other    = entry.other;
         r.object   = entry.object;
      end
      return r;
   endfunction

   task automatic report_field(input string what, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
         failures++;
      end
   endtask

   // Compare every result word with the oldest expectation.
   always @(posedge clock) begin : result_check
      cell_report_type want;
      if (!reset && rsp_strobe) begin
         if (pending_reports.size() == 0) begin
            $display("%0t: result word with nothing expected, occupancy %0d",
                     $time, rsp_occupancy);
            failures++;
         end else begin
            want = pending_reports.pop_front();
            report_field("in_range",   want.in_range, rsp_in_range);
            report_field("occupancy",  want.occ,      rsp_occupancy);
            report_field("sonar_seen", want.sonar,    rsp_sonar_seen);
            report_field("other_seen", want.other,    rsp_other_seen);
            report_field("object_set", want.object,   rsp_object_set);
            report_field("frame_done", want.frame,    rsp_frame_done);
         end
      end
   end

   // Offer one word; idle in random gaps between bursts. Return at the accepting edge
   // without touching start, so the next word can follow in the very next cycle.
   task automatic send_point(input point_word_type w, input bit use_typed,
                             input cell_report_type typed);
      int              gap;
      cell_report_type predicted;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      start              <= 1'b1;
      req_cmd            <= w.cmd;
      req_pos_x          <= w.pos_x;
      req_pos_y          <= w.pos_y;
      req_cluster_active <= w.active;
      req_last_in_frame  <= w.last;
      @(posedge clock);
      while (busy) @(posedge clock);
      predicted = predict_cell_update(w);
      pending_reports.push_back(use_typed ? typed : predicted);
   endtask

   // Drop start and hold until every result is in, then let the pipe settle.
   task automatic wait_drained();
      start <= 1'b0;
      burst_left = 0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register transfers run back to back; check_settings returns the bus to idle.
   task automatic csr_write(input logic [2:0] idx,
                            input logic [ogu_pkg::CSR_DATA_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      case (idx)
         ogu_pkg::REG_COLUMN_OFFSET: grid_col_offset = value[ogu_pkg::OFFSET_W-1:0];
         ogu_pkg::REG_ROW_OFFSET:    grid_row_offset = value[ogu_pkg::OFFSET_W-1:0];
         ogu_pkg::REG_STEP:          hit_step        = value[ogu_pkg::OCC_W-1:0];
         ogu_pkg::REG_CEILING:       count_ceiling   = value[ogu_pkg::OCC_W-1:0];
         ogu_pkg::REG_THRESHOLD:     object_level    = value[ogu_pkg::OCC_W-1:0];
         default: ;
      endcase
   endtask

   task automatic csr_read(input logic [2:0] idx,
                           input logic [ogu_pkg::CSR_DATA_W-1:0] want);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {idx, 2'b00};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (prdata !== want) begin
         $display("%0t: register %0d read mismatch, expected %0d, actual %0d",
                  $time, idx, want, prdata);
         failures++;
      end
   endtask

   task automatic check_settings();
      csr_read(ogu_pkg::REG_COLUMN_OFFSET, ogu_pkg::CSR_DATA_W'(grid_col_offset));
      csr_read(ogu_pkg::REG_ROW_OFFSET,    ogu_pkg::CSR_DATA_W'(grid_row_offset));
      csr_read(ogu_pkg::REG_STEP,          ogu_pkg::CSR_DATA_W'(hit_step));
      csr_read(ogu_pkg::REG_CEILING,       ogu_pkg::CSR_DATA_W'(count_ceiling));
      csr_read(ogu_pkg::REG_THRESHOLD,     ogu_pkg::CSR_DATA_W'(object_level));
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   initial begin : stimulus
      point_word_type   w;
      cell_report_type  typed;
      grid_setting_type s;
      int               hot_col [HOT_CELLS];
      int               hot_row [HOT_CELLS];
      int               col;
      int               row;
      int               x;
      int               y;
      int               pick;

      for (int i = 0; i < ogu_pkg::CELL_COUNT; i++)
         grid_mirror[i] = '0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      // hold off until the clearing sweep is over
      @(posedge clock);
      while (busy) @(posedge clock);
      check_settings();

      // directed part
      foreach (directed_points[i]) begin
         w.cmd    = directed_points[i].cmd[ogu_pkg::CMD_W-1:0];
         x        = directed_points[i].x;
         y        = directed_points[i].y;
         w.pos_x  = x[ogu_pkg::POS_W-1:0];
         w.pos_y  = y[ogu_pkg::POS_W-1:0];
         w.active = directed_points[i].active;
         w.last   = directed_points[i].last;
         typed.in_range = directed_points[i].in_range;
         typed.occ      = directed_points[i].occ[ogu_pkg::OCC_W-1:0];
         typed.sonar    = directed_points[i].sonar;
         typed.other    = directed_points[i].other;
         typed.object   = directed_points[i].object;
         typed.frame    = directed_points[i].last;
         send_point(w, directed_points[i].typed, typed);
      end

      // random part, one register setting per phase
      for (int p = 0; p < PHASES; p++) begin
         if (p > 0) begin
            wait_drained();
            if (p < FIXED_PHASES) begin
               s = fixed_settings[p];
            end else begin
               s.col_off = $urandom_range(0, 2175);
               s.row_off = $urandom_range(0, 2111);
               s.step    = $urandom_range(0, 255);
               s.ceil    = $urandom_range(0, 255);
               s.thr     = $urandom_range(0, 255);
            end
            csr_write(ogu_pkg::REG_COLUMN_OFFSET, s.col_off);
            csr_write(ogu_pkg::REG_ROW_OFFSET,    s.row_off);
            csr_write(ogu_pkg::REG_STEP,          s.step);
            csr_write(ogu_pkg::REG_CEILING,       s.ceil);
            csr_write(ogu_pkg::REG_THRESHOLD,     s.thr);
            check_settings();
         end
         // a few hot cells get hit over and over to drive counts into saturation
         for (int h = 0; h < HOT_CELLS; h++) begin
            hot_col[h] = $urandom_range(0, ogu_pkg::GRID_COLS - 1);
            hot_row[h] = $urandom_range(0, ogu_pkg::GRID_ROWS - 1);
         end
         for (int n = 0; n < phase_points[p]; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 85) begin
               // point aimed at a grid cell under the current offsets
               if ($urandom_range(0, 1) == 0) begin
                  pick = $urandom_range(0, HOT_CELLS - 1);
                  col = hot_col[pick];
                  row = hot_row[pick];
               end else begin
                  col = $urandom_range(0, ogu_pkg::GRID_COLS - 1);
                  row = $urandom_range(0, ogu_pkg::GRID_ROWS - 1);
               end
            end else if (pick < 92) begin
               // just past an edge
               col = ($urandom_range(0, 1) == 0) ? -1 : ogu_pkg::GRID_COLS;
               row = $urandom_range(0, ogu_pkg::GRID_ROWS);
            end else begin
               col = 1 << 20;
               row = 1 << 20;
            end
            x = col - int'(grid_col_offset);
            y = row - int'(grid_row_offset);
            if (x < -2048 || x > 2047)
               x = $urandom_range(0, 4095);
            if (y < -2048 || y > 2047)
               y = $urandom_range(0, 4095);
            w.pos_x = x[ogu_pkg::POS_W-1:0];
            w.pos_y = y[ogu_pkg::POS_W-1:0];
            pick = $urandom_range(0, 99);
            if (pick < 40)
               w.cmd = ogu_pkg::CMD_SONAR;
            else if (pick < 75)
               w.cmd = ogu_pkg::CMD_OTHER;
            else if (pick < 90)
               w.cmd = ogu_pkg::CMD_READ;
            else
               w.cmd = CMD_UNUSED;
            w.active = ($urandom_range(0, 9) != 0);
            w.last   = ($urandom_range(0, 15) == 0);
            // now and then stop mid-phase until the block is empty
            if ($urandom_range(0, 149) == 0)
               wait_drained();
            send_point(w, 1'b0, '0);
         end
      end

      wait_drained();
      if (failures == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   // watchdog with a wide margin over the expected run of the stimulus
   initial begin : watchdog
      #2_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule

// File: sim.f
rtl/ogu_pkg.sv
rtl/ogu_ram.sv
rtl/ogu_front.sv
rtl/ogu_queue.sv
rtl/ogu_back.sv
rtl/occupancy_grid_update.sv
rtl/ogu_checker.sv
dv/tb_occupancy_grid_update.sv
